>>> rtl/core/lsra_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the linear scan register allocator.
// No dependencies; every other file in rtl/core refers to this package.
package lsra_pkg;

   localparam int unsigned POS_W        = 16;
   localparam int unsigned ID_W         = 16;
   localparam int unsigned REG_IDX_W    = 4;
   localparam int unsigned SLOT_W       = 16;
   localparam int unsigned FREE_W       = 5;
   localparam int unsigned CFG_W        = 5;
   localparam int unsigned QUEUE_DEPTH  = 4;
   localparam int unsigned QPTR_W       = 2;
   localparam int unsigned QCNT_W       = 3;

   localparam logic [CFG_W-1:0]  ACTIVE_REGS_RESET = 5'd16;
   localparam logic [SLOT_W-1:0] SPILL_TOP         = 16'hFFFF;

   // Input transaction; var_id sits in the lowest bits.
   typedef struct packed {
      logic [POS_W-1:0] end_pos;
      logic [POS_W-1:0] start_pos;
      logic [ID_W-1:0]  var_id;
   } req_item_type;

   // Result data word; var_id_out sits in the lowest bits.
   typedef struct packed {
      logic [6:0]           pad;
      logic [FREE_W-1:0]    free_count;
      logic [SLOT_W-1:0]    spill_total;
      logic [SLOT_W-1:0]    spill_slot;
      logic [REG_IDX_W-1:0] reg_index;
      logic [ID_W-1:0]      var_id_out;
   } rsp_data_type;

endpackage

>>> rtl/core/lsra_front.sv
`timescale 1ns / 1ps
// Intake stage of the allocator: registers each accepted interval and hands
// it to the queue. Depends on lsra_pkg.
module lsra_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lsra_pkg::req_item_type req_item,
   output logic                  push_valid,
   input  logic                  push_ready,
   output lsra_pkg::req_item_type push_item
);

   logic                   hold_valid_ff;
   logic                   hold_valid_in;
   lsra_pkg::req_item_type item_ff;
   logic                   take;

   assign req_ready  = !hold_valid_ff || push_ready;
   assign take       = req_valid && req_ready;
   assign push_valid = hold_valid_ff;
   assign push_item  = item_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (take) begin
         hold_valid_in = 1'b1;
      end else if (push_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
      end
   end

endmodule

>>> rtl/core/lsra_queue.sv
`timescale 1ns / 1ps
// Short first-in first-out queue of intervals between intake and allocation.
// Depends on lsra_pkg.
module lsra_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  lsra_pkg::req_item_type push_item,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output lsra_pkg::req_item_type pop_item
);

   lsra_pkg::req_item_type entries_ff [lsra_pkg::QUEUE_DEPTH];
   logic [lsra_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [lsra_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [lsra_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                        do_push;
   logic                        do_pop;

   assign push_ready = count_ff != lsra_pkg::QCNT_W'(lsra_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/core/lsra_back.sv
`timescale 1ns / 1ps
// Allocation stage: expires finished intervals, picks the lowest free register
// or a spill slot, and holds the result in an output register. Depends on lsra_pkg.
module lsra_back #(
   parameter int unsigned MAX_REGS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [lsra_pkg::CFG_W-1:0]   csr_wr_data,
   input  logic                         pop_valid,
   output logic                         pop_ready,
   input  lsra_pkg::req_item_type       pop_item,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output lsra_pkg::rsp_data_type       rsp_data,
   output logic                         rsp_spilled
);

   localparam int unsigned PICK_W = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;

   logic [lsra_pkg::CFG_W-1:0]  active_regs_ff;
   logic [MAX_REGS-1:0]         busy_ff, busy_in;
   logic [lsra_pkg::POS_W-1:0]  end_ff [MAX_REGS];
   logic [lsra_pkg::SLOT_W-1:0] spill_cnt_ff, spill_cnt_in;
   logic                        out_valid_ff, out_valid_in;
   lsra_pkg::rsp_data_type      out_data_ff, out_data_in;
   logic                        out_spilled_ff;

   logic [MAX_REGS-1:0]         eligible;
   logic [MAX_REGS-1:0]         expired;
   logic [MAX_REGS-1:0]         free_elig;
   logic [PICK_W-1:0]           pick;
   logic                        found;
   logic                        take;

   assign pop_ready   = !out_valid_ff || rsp_ready;
   assign take        = pop_valid && pop_ready;
   assign rsp_valid   = out_valid_ff;
   assign rsp_data    = out_data_ff;
   assign rsp_spilled = out_spilled_ff;

   for (genvar g = 0; g < MAX_REGS; g++) begin : g_reg
      assign eligible[g]  = int'(active_regs_ff) > g;
      assign expired[g]   = busy_ff[g] && (end_ff[g] <= pop_item.start_pos);
      assign free_elig[g] = eligible[g] && !(busy_ff[g] && !expired[g]);
   end

   always_comb begin
      pick = '0;
      for (int i = MAX_REGS - 1; i >= 0; i--) begin
         if (free_elig[i]) begin
            pick = PICK_W'(i);
         end
      end
   end

   assign found = |free_elig;

   always_comb begin
      busy_in      = busy_ff;
      spill_cnt_in = spill_cnt_ff;
      if (take) begin
         busy_in = busy_ff & ~expired;
         if (found) begin
            busy_in[pick] = 1'b1;
         end else if (spill_cnt_ff != lsra_pkg::SPILL_TOP) begin
            spill_cnt_in = spill_cnt_ff + 1'b1;
         end
      end
   end

   always_comb begin
      out_data_in             = '0;
      out_data_in.var_id_out  = pop_item.var_id;
      out_data_in.reg_index   = found ? lsra_pkg::REG_IDX_W'(pick) : '0;
      out_data_in.spill_slot  = found ? '0 : spill_cnt_ff;
      out_data_in.spill_total = spill_cnt_in;
      out_data_in.free_count  = lsra_pkg::FREE_W'($countones(free_elig) - int'(found));
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (take) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_regs_ff <= lsra_pkg::ACTIVE_REGS_RESET;
         busy_ff        <= '0;
         spill_cnt_ff   <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            active_regs_ff <= csr_wr_data;
         end
         busy_ff      <= busy_in;
         spill_cnt_ff <= spill_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_data_ff    <= out_data_in;
         out_spilled_ff <= !found;
         if (found) begin
            end_ff[pick] <= pop_item.end_pos;
         end
      end
   end

   a_pick_marks_busy: assert property (@(posedge clock) disable iff (reset)
      take && found |=> busy_ff[$past(pick)])
      else $error("allocated register not marked busy");

   a_spill_advances: assert property (@(posedge clock) disable iff (reset)
      take && !found && spill_cnt_ff != lsra_pkg::SPILL_TOP
      |=> spill_cnt_ff == $past(spill_cnt_ff) + 1'b1)
      else $error("spill counter did not advance on spill");

   a_alloc_keeps_counter: assert property (@(posedge clock) disable iff (reset)
      take && found |=> $stable(spill_cnt_ff))
      else $error("spill counter moved on allocation");

   a_stall_holds_result: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |=> out_valid_ff && $stable(out_data_ff))
      else $error("pending result overwritten");

   a_spill_fields: assert property (@(posedge clock) disable iff (reset)
      take && found |=> !out_spilled_ff && out_data_ff.spill_slot == '0)
      else $error("allocated result carries a spill slot");

endmodule

>>> rtl/core/linear_scan_register_allocator.sv
`timescale 1ns / 1ps
// Sustains one interval per clock cycle while rsp_tready does not stall it:
// each accepted transaction passes an intake register, a four-entry queue and
// the output register of the allocation stage before its result is offered.
// The allocation stage frees expired registers, picks the lowest free one and
// updates the busy flags, all in the same cycle, which sets the rate.
// Depends on lsra_pkg, lsra_front, lsra_queue and lsra_back.
module linear_scan_register_allocator #(
   parameter int unsigned MAX_REGS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [lsra_pkg::CFG_W-1:0] csr_wr_data,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [47:0]                req_tdata,  // var_id, start_pos, end_pos
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [63:0]                rsp_tdata,  // var_id_out, reg_index,
                                                  // spill_slot, spill_total,
                                                  // free_count, zero fill
   output logic                       rsp_tuser   // spilled
);

   logic                   push_valid;
   logic                   push_ready;
   lsra_pkg::req_item_type push_item;
   logic                   pop_valid;
   logic                   pop_ready;
   lsra_pkg::req_item_type pop_item;
   lsra_pkg::rsp_data_type rsp_data;

   lsra_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_item   (lsra_pkg::req_item_type'(req_tdata)),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   lsra_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   lsra_back #(
      .MAX_REGS (MAX_REGS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_item    (pop_item),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_data    (rsp_data),
      .rsp_spilled (rsp_tuser)
   );

   assign rsp_tdata = rsp_data;

endmodule
